/* sv/esd_pkg.sv */
// Shared types and constants for the escape sequence decoder.
package esd_pkg;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One result beat.
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
    } t_res;

    // Up to two result beats produced by one input beat.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_pair;

endpackage

/* sv/escape_sequence_decoder_core.sv */
// Top level of the backslash escape decoder.
//
// Input channel: i_valid / o_ready carry one beat per string byte (i_op low,
// byte on i_in_byte) or an end of string beat (i_op high). Output channel:
// o_valid / i_ready carry decoded data bytes (o_kind low) and the end marker
// (o_kind high, o_out_byte zero). Decoded zero bytes are dropped.
// Throughput: one input beat per cycle while the queue has room, and one
// output beat per cycle while the receiver is ready. An input beat gives
// zero, one or two output beats; a beat that gives two holds the back end
// for both of its output beats, so a sustained run of such beats drains at
// half rate once the queue fills. The first result of an accepted beat is
// written into the queue and then loaded from the queue into the back end's
// output register, which drives the outputs.
// When the receiver stalls, the output register holds its beat, the queue
// keeps taking results and o_ready falls only when the queue is full.
// Synchronous active-low reset returns the escape state machine to idle
// with no escape pending and empties the queue and the output register.
module escape_sequence_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [7:0] o_out_byte
);
    import esd_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_pair push_pair;
    t_pair pop_pair;

    // Front end classifies each byte and updates the escape state.
    esd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_push    (push),
        .o_pair    (push_pair)
    );

    // The queue decouples byte intake from the output handshake.
    esd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_pair  (pop_pair)
    );

    // Back end serializes each queued pair into output beats.
    esd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_pair     (pop_pair),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte)
    );

endmodule

/* sv/esd_front.sv */
// Front end: accepts input beats, runs the escape state machine, queues the results.
module esd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic [7:0]    i_in_byte,
    input  logic          i_full,
    output logic          o_push,
    output esd_pkg::t_pair o_pair
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BSL,
        MODE_HEX0,
        MODE_HEX1,
        MODE_OCT1,
        MODE_OCT2
    } t_mode;

    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_N    = 8'h6e;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;

    t_mode      r_mode, n_mode;
    logic [7:0] r_value, n_value;

    logic       accept;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       oct_ok;
    logic       flush_en;
    logic [7:0] flush_val;
    logic       emit_en;
    logic [7:0] emit_val;
    logic       end_en;
    logic       run_idle;
    logic [7:0] simple_val;

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_in_byte >= CH_0 && i_in_byte <= CH_9) begin
            hex_val = 4'(i_in_byte - CH_0);
        end else if (i_in_byte >= CH_LA && i_in_byte <= CH_LF) begin
            hex_val = 4'(i_in_byte - CH_LA + 8'd10);
        end else if (i_in_byte >= CH_UA && i_in_byte <= CH_UF) begin
            hex_val = 4'(i_in_byte - CH_UA + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign oct_ok = (i_in_byte >= CH_0) && (i_in_byte <= CH_7);

    always_comb begin
        case (i_in_byte)
            CH_LA:   simple_val = 8'd7;
            CH_B:    simple_val = 8'd8;
            CH_LF:   simple_val = 8'd12;
            CH_N:    simple_val = 8'd10;
            CH_R:    simple_val = 8'd13;
            CH_T:    simple_val = 8'd9;
            default: simple_val = i_in_byte;
        endcase
    end

    // Decide what this beat flushes, emits and leaves behind.
    always_comb begin
        n_mode    = r_mode;
        n_value   = r_value;
        flush_en  = 1'b0;
        flush_val = r_value;
        emit_en   = 1'b0;
        emit_val  = 8'd0;
        end_en    = 1'b0;
        run_idle  = 1'b0;
        if (i_op) begin
            end_en  = 1'b1;
            n_mode  = MODE_IDLE;
            n_value = 8'd0;
            case (r_mode)
                MODE_BSL: begin
                    flush_en  = 1'b1;
                    flush_val = CH_BSL;
                end
                MODE_HEX1, MODE_OCT1, MODE_OCT2: flush_en = 1'b1;
                default: flush_en = 1'b0;
            endcase
        end else begin
            case (r_mode)
                MODE_BSL: begin
                    if (i_in_byte == CH_X) begin
                        n_mode  = MODE_HEX0;
                        n_value = 8'd0;
                    end else if (i_in_byte >= CH_0 && i_in_byte <= CH_3) begin
                        n_mode  = MODE_OCT1;
                        n_value = i_in_byte - CH_0;
                    end else begin
                        n_mode   = MODE_IDLE;
                        emit_en  = 1'b1;
                        emit_val = simple_val;
                    end
                end
                MODE_HEX0: begin
                    if (hex_ok) begin
                        n_mode  = MODE_HEX1;
                        n_value = {4'd0, hex_val};
                    end else begin
                        run_idle = 1'b1;
                    end
                end
                MODE_HEX1: begin
                    if (hex_ok) begin
                        emit_en  = 1'b1;
                        emit_val = {r_value[3:0], hex_val};
                        n_mode   = MODE_IDLE;
                        n_value  = 8'd0;
                    end else begin
                        flush_en = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_OCT1: begin
                    if (oct_ok) begin
                        n_mode  = MODE_OCT2;
                        n_value = {r_value[4:0], i_in_byte[2:0]};
                    end else begin
                        flush_en = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_OCT2: begin
                    if (oct_ok) begin
                        emit_en  = 1'b1;
                        emit_val = {r_value[4:0], i_in_byte[2:0]};
                        n_mode   = MODE_IDLE;
                        n_value  = 8'd0;
                    end else begin
                        flush_en = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                default: run_idle = 1'b1;
            endcase
            if (run_idle) begin
                n_value = 8'd0;
                if (i_in_byte == CH_BSL) begin
                    n_mode = MODE_BSL;
                end else begin
                    n_mode   = MODE_IDLE;
                    emit_en  = 1'b1;
                    emit_val = i_in_byte;
                end
            end
        end
    end

    // Pack the nonzero data beats and the end marker into the queue entry.
    always_comb begin
        t_res list [3];
        logic [1:0] cnt;
        list[0] = '0;
        list[1] = '0;
        list[2] = '0;
        cnt     = 2'd0;
        if (flush_en && flush_val != 8'd0) begin
            list[0] = '{kind: KIND_DATA, out_byte: flush_val};
            cnt     = 2'd1;
        end
        if (emit_en && emit_val != 8'd0) begin
            list[cnt] = '{kind: KIND_DATA, out_byte: emit_val};
            cnt       = cnt + 2'd1;
        end
        if (end_en) begin
            list[cnt] = '{kind: KIND_END, out_byte: 8'd0};
            cnt       = cnt + 2'd1;
        end
        o_pair.cnt = cnt;
        o_pair.r0  = list[0];
        o_pair.r1  = list[1];
        o_push     = accept && (cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_value <= 8'd0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_value <= n_value;
        end
    end

endmodule

/* sv/esd_fifo.sv */
// Short queue of result pairs between the front and back ends.
module esd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  esd_pkg::t_pair i_pair,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output esd_pkg::t_pair o_pair
);
    import esd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_pair         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL);
    assign o_empty = (r_count == '0);
    assign o_pair  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/esd_back.sv */
// Back end: splits queued result pairs into single output beats.
module esd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  esd_pkg::t_pair i_pair,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [7:0]     o_out_byte
);
    import esd_pkg::*;

    logic r_valid;
    t_res r_res;
    logic r_pend;
    t_res r_pend_res;
    logic load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_res   <= r_pend_res;
                r_pend  <= 1'b0;
            end else if (!i_empty) begin
                r_valid    <= 1'b1;
                r_res      <= i_pair.r0;
                r_pend     <= (i_pair.cnt == 2'd2);
                r_pend_res <= i_pair.r1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_res.kind;
    assign o_out_byte = r_res.out_byte;

endmodule

/* tb/escape_sequence_decoder_core_test.sv */
// Self-checking testbench for the backslash escape decoder core.
module escape_sequence_decoder_core_test;
    import esd_pkg::*;

    // Beat codes on the input channel.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Characters that steer the escape decoding.
    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // The run is short; this bound is far above the slowest legal run.
    localparam int CYCLE_LIMIT = 400_000;
    // Cycles waited after the last owed beat has come out before the run is closed.
    localparam int DRAIN_CYCLES = 8;
    // Length of the long receiver stall that forces o_ready low.
    localparam int STALL_CYCLES = 300;

    // Escape progress, mirrored from the decoder's behavior.
    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_BSL,
        ESC_HEX0,
        ESC_HEX1,
        ESC_OCT1,
        ESC_OCT2
    } esc_state_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_op;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_kind;
    logic [7:0] o_out_byte;

    escape_sequence_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte)
    );

    always #6 i_clk = ~i_clk;

    // Predicted decoder state and the decoded beats still owed by the block.
    esc_state_t esc_state = ESC_IDLE;
    logic [7:0] esc_acc   = 8'h00;
    t_res       owed_beats[$];

    // Idle percentages for each side, and the long stall request.
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_rx     = 1'b0;

    int  err_count   = 0;
    int  beats_in    = 0;
    int  ends_in     = 0;
    int  beats_out   = 0;
    int  cycle_count = 0;

    string hex_chars    = "0123456789abcdefABCDEF";
    string simple_chars = "abfnrt\\\"?'v";
    string noise_chars  = "\\xX0123789aAfFgG";

    // The watchdog ends a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still owed", cycle_count,
                     owed_beats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Hex digit value, or -1 when the byte is not a hex digit.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        case (c)
            "a": return 8'd7;
            "b": return 8'd8;
            "f": return 8'd12;
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            default: return c;
        endcase
    endfunction

    // Zero data values are dropped by the decoder, so they are never owed.
    task automatic owe_data(input logic [7:0] b);
        t_res r;
        if (b != 8'h00) begin
            r.kind     = KIND_DATA;
            r.out_byte = b;
            owed_beats.push_back(r);
        end
    endtask

    // Advances the predicted state by one accepted beat and records what
    // the block has to produce for it.
    task automatic decode_beat(input logic op, input logic [7:0] c);
        t_res r;
        int   d;
        d = hex_value(c);
        if (op == OP_END) begin
            // A pending escape is flushed before the end marker.
            if (esc_state == ESC_BSL)
                owe_data(CH_BSL);
            else if (esc_state inside {ESC_HEX1, ESC_OCT1, ESC_OCT2})
                owe_data(esc_acc);
            esc_state = ESC_IDLE;
            esc_acc   = 8'h00;
            r.kind     = KIND_END;
            r.out_byte = 8'h00;
            owed_beats.push_back(r);
            return;
        end
        case (esc_state)
            ESC_BSL: begin
                if (c == CH_X) begin
                    esc_state = ESC_HEX0;
                    esc_acc   = 8'h00;
                end else if (c >= "0" && c <= "3") begin
                    esc_state = ESC_OCT1;
                    esc_acc   = c - CH_ZERO;
                end else begin
                    esc_state = ESC_IDLE;
                    owe_data(simple_escape(c));
                end
                return;
            end
            ESC_HEX0: begin
                if (d >= 0) begin
                    esc_acc   = 8'(d);
                    esc_state = ESC_HEX1;
                    return;
                end
            end
            ESC_HEX1: begin
                if (d >= 0) begin
                    owe_data(8'(esc_acc * 16 + d));
                    esc_state = ESC_IDLE;
                    esc_acc   = 8'h00;
                    return;
                end
                owe_data(esc_acc);
            end
            ESC_OCT1, ESC_OCT2: begin
                if (c >= "0" && c <= "7") begin
                    if (esc_state == ESC_OCT1) begin
                        esc_acc   = 8'(esc_acc * 8 + (c - CH_ZERO));
                        esc_state = ESC_OCT2;
                    end else begin
                        owe_data(8'(esc_acc * 8 + (c - CH_ZERO)));
                        esc_state = ESC_IDLE;
                        esc_acc   = 8'h00;
                    end
                    return;
                end
                owe_data(esc_acc);
            end
            default: ;
        endcase
        // A short escape ends here: the byte that ended it is handled as if
        // no escape were pending.
        esc_state = ESC_IDLE;
        esc_acc   = 8'h00;
        if (c == CH_BSL)
            esc_state = ESC_BSL;
        else
            owe_data(c);
    endtask

    // Offers one beat, idling the channel first at the current rate, and
    // predicts its results once the block takes it.
    task automatic send_beat(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_op      <= op;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        decode_beat(op, b);
        beats_in++;
        if (op == OP_END)
            ends_in++;
    endtask

    // The byte on an end beat is ignored by the block, so it is random.
    task automatic send_end();
        send_beat(OP_END, 8'($urandom_range(255)));
    endtask

    task automatic send_text(input string s);
        foreach (s[k])
            send_beat(OP_BYTE, s[k]);
    endtask

    // One random piece of a string: mostly well-formed escapes with random
    // content, some plain bytes, end beats and noise that breaks escapes.
    task automatic send_random_piece();
        int pick;
        int ndig;
        pick = $urandom_range(99);
        if (pick < 22) begin
            send_beat(OP_BYTE, 8'($urandom_range(255, 1)));
        end else if (pick < 37) begin
            send_beat(OP_BYTE, CH_BSL);
            if ($urandom_range(3) == 0)
                send_beat(OP_BYTE, 8'($urandom_range(255, 1)));
            else
                send_beat(OP_BYTE, simple_chars[$urandom_range(simple_chars.len() - 1)]);
        end else if (pick < 55) begin
            send_beat(OP_BYTE, CH_BSL);
            send_beat(OP_BYTE, CH_X);
            ndig = $urandom_range(2);
            repeat (ndig)
                send_beat(OP_BYTE, hex_chars[$urandom_range(hex_chars.len() - 1)]);
            if (ndig < 2 && $urandom_range(1) == 1)
                send_beat(OP_BYTE, noise_chars[$urandom_range(noise_chars.len() - 1)]);
        end else if (pick < 73) begin
            send_beat(OP_BYTE, CH_BSL);
            send_beat(OP_BYTE, 8'(CH_ZERO + $urandom_range(3)));
            ndig = $urandom_range(2);
            repeat (ndig)
                send_beat(OP_BYTE, 8'(CH_ZERO + $urandom_range(7)));
            if (ndig < 2 && $urandom_range(1) == 1)
                send_beat(OP_BYTE, noise_chars[$urandom_range(noise_chars.len() - 1)]);
        end else if (pick < 83) begin
            send_end();
        end else if (pick < 93) begin
            send_beat(OP_BYTE, noise_chars[$urandom_range(noise_chars.len() - 1)]);
        end else begin
            // Bytes with the top bit set are never digits.
            send_beat(OP_BYTE, 8'($urandom_range(255, 128)));
        end
    endtask

    task automatic send_random_beats(input int count);
        int first;
        first = beats_in;
        while (beats_in - first < count)
            send_random_piece();
    endtask

    // The receiver is ready at random unless a long stall is in force.
    always @(negedge i_clk) begin
        if (hold_rx)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic flag_mismatch(input string what, input t_res want, input logic kind,
                                 input logic [7:0] b);
        err_count++;
        if (err_count <= 10)
            $display("Mismatch (%s) at cycle %0d: expected kind %0b byte 0x%02h, %s",
                     what, cycle_count, want.kind, want.out_byte,
                     $sformatf("got kind %0b byte 0x%02h", kind, b));
    endtask

    // Every result beat is matched against the oldest owed beat.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            beats_out++;
            if (owed_beats.size() == 0) begin
                want = '0;
                flag_mismatch("unexpected beat", want, o_kind, o_out_byte);
            end else begin
                want = owed_beats.pop_front();
                if (o_kind !== want.kind)
                    flag_mismatch("kind", want, o_kind, o_out_byte);
                else if (o_out_byte !== want.out_byte)
                    flag_mismatch("byte", want, o_kind, o_out_byte);
            end
        end
    end

    // Short strings for the extremes of the byte field and every escape
    // form, including short escapes cut off by a backslash, by a non-digit
    // and by the end of the string.
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_beat(OP_BYTE, 8'h01);
        send_text("\\a\\x4F\\x7\\");
        send_end();
        send_text("\\377\\18\\x");
        send_beat(OP_BYTE, 8'hff);
        send_text("\\0");
        send_end();
    endtask

    task automatic test_random_mix(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        send_random_beats(count);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats, so the queue fills and the block stalls its input.
    task automatic test_receiver_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                hold_rx = 1'b1;
                repeat (STALL_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            send_random_beats(80);
        join
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_op      = OP_BYTE;
        i_in_byte = 8'h00;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(21, 74, 600);
        test_random_mix(74, 21, 600);
        test_random_mix(0, 0, 600);
        test_receiver_stall();

        @(negedge i_clk);
        i_valid <= 1'b0;
        rx_idle_pct = 0;
        while (owed_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input beats (%0d end of string) and checked %0d result beats",
                 beats_in, ends_in, beats_out);
        $display("over three idling mixes and one long receiver stall; %0d mismatches",
                 err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
